// ===== sv/nfw_pkg.sv =====
// shared constants and types for the near/far word lz expander
package nfw_pkg;

  localparam int HISTORY_WORDS = 32768;
  localparam int ADDR_W        = $clog2(HISTORY_WORDS);
  localparam int POS_W         = ADDR_W + 1;
  localparam int LEN_W         = (POS_W + 1 > 17) ? POS_W + 1 : 17;
  localparam int SRC_W         = 18;

  localparam logic [7:0] NEAR_TAG = 8'hA7;
  localparam logic [7:0] FAR_TAG  = 8'hA8;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNWRITTEN = 2'd1;
  localparam logic [1:0] ERR_CUT       = 2'd2;

  typedef enum logic [5:0] {
    PH_HDR0  = 6'b000001,
    PH_HDR1  = 6'b000010,
    PH_LOW   = 6'b000100,
    PH_HIGH  = 6'b001000,
    PH_ARG   = 6'b010000,
    PH_FARHI = 6'b100000
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_PUSH  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_NEAR = 2'd1,
    KIND_FAR  = 2'd2
  } kind_t;

endpackage

// ===== sv/nfw_if.sv =====
// stream interfaces for the compressed byte input and the expanded word output
interface nfw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_first;

  modport source (output valid, output data_byte, output stream_first, input ready);
  modport sink (input valid, input data_byte, input stream_first, output ready);
endinterface

interface nfw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_a;
  logic [15:0] word_b;
  logic [15:0] word_c;
  logic [15:0] word_d;
  logic [2:0]  words_valid;
  logic        run_last;
  logic        stream_done;
  logic [1:0]  error_code;

  modport source (output valid, output word_a, output word_b, output word_c,
                  output word_d, output words_valid, output run_last,
                  output stream_done, output error_code, input ready);
  modport sink (input valid, input word_a, input word_b, input word_c,
                input word_d, input words_valid, input run_last,
                input stream_done, input error_code, output ready);
endinterface

// ===== sv/near_far_word_lz_expander.sv =====
// near/far word lz expander top level with history ram and copy engine
// Takes one compressed byte per beat and expands it into 16-bit words that
// leave in beats of up to four words; each word arrives low byte first.
// Header, tag and argument bytes are taken in the idle state; a byte that
// completes a literal word writes it to the history ram, and the push state
// then moves its beat into the output register. A copy run reads each word
// from the history ram in the read state and writes it back in the write
// state; after every fourth word and the last, the push state moves the beat
// out once the output register is free. The input is not taken while a run
// is being copied. No clearing pass is needed after reset.
module near_far_word_lz_expander (
  input  logic             clk,
  input  logic             rst_n,
  nfw_in_if.sink           in_ch,
  nfw_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  nfw_pkg::state_t state_r, state_nxt;
  nfw_pkg::phase_t phase_r, phase_nxt;
  nfw_pkg::kind_t  kind_r, kind_nxt;

  logic [15:0]                   cfg_r;
  logic [nfw_pkg::POS_W-1:0]     wp_r, wp_nxt;
  logic [7:0]                    held_low_r, held_low_nxt;
  logic [7:0]                    held_count_r, held_count_nxt;
  logic [7:0]                    far_low_r, far_low_nxt;
  logic signed [nfw_pkg::SRC_W-1:0] src_r, src_nxt;
  logic [7:0]                    rem_r, rem_nxt;
  logic                          cut_r, cut_nxt;
  logic                          ok_r, ok_nxt;
  logic                          more_r, more_nxt;
  logic [1:0]                    slot_r, slot_nxt;

  logic [15:0] stage_w_r [4];
  logic [15:0] stage_w_nxt [4];
  logic        stage_err_r, stage_err_nxt;
  logic [2:0]  stage_cnt_r, stage_cnt_nxt;
  logic        stage_last_r, stage_last_nxt;
  logic        stage_done_r, stage_done_nxt;
  logic [1:0]  stage_code_r, stage_code_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_w_r [4];
  logic [15:0] out_w_nxt [4];
  logic [2:0]  out_cnt_r, out_cnt_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_done_r, out_done_nxt;
  logic [1:0]  out_code_r, out_code_nxt;

  logic [15:0] history_mem [nfw_pkg::HISTORY_WORDS];
  logic [15:0] rdata_r;
  logic        mem_we;
  logic [15:0] mem_wdata;
  logic        mem_re;

  logic [nfw_pkg::POS_W-1:0]     lim;
  logic [nfw_pkg::POS_W-1:0]     wp_inc;
  logic                          in_fire;
  logic                          out_free;
  logic [7:0]                    b;
  logic [7:0]                    kind_byte;
  logic                          lit_go;
  logic [15:0]                   lit_word;
  logic                          run_go;
  logic signed [nfw_pkg::SRC_W-1:0] run_src;
  logic [nfw_pkg::LEN_W-1:0]     run_end;
  logic                          run_cut;
  logic [15:0]                   cp_word;
  logic                          cp_last;
  logic                          src_ok;

  assign lim = (nfw_pkg::LEN_W'(cfg_r) > nfw_pkg::LEN_W'(nfw_pkg::HISTORY_WORDS)) ?
               nfw_pkg::POS_W'(nfw_pkg::HISTORY_WORDS) : nfw_pkg::POS_W'(cfg_r);
  assign wp_inc   = wp_r + nfw_pkg::POS_W'(1);
  assign in_ch.ready = (state_r == nfw_pkg::ST_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign b        = in_ch.data_byte;
  assign kind_byte = (kind_r == nfw_pkg::KIND_NEAR) ? nfw_pkg::NEAR_TAG : nfw_pkg::FAR_TAG;
  assign run_end  = nfw_pkg::LEN_W'(wp_r) + nfw_pkg::LEN_W'(held_count_r);
  assign run_cut  = run_end > nfw_pkg::LEN_W'(lim);
  assign src_ok   = !src_r[nfw_pkg::SRC_W-1] &&
                    (src_r < $signed(nfw_pkg::SRC_W'(wp_r)));
  assign cp_word  = ok_r ? rdata_r : 16'h0000;
  assign cp_last  = (rem_r == 8'd1);

  always_comb begin
    lit_go   = 1'b0;
    lit_word = 16'h0000;
    run_go   = 1'b0;
    run_src  = '0;
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    held_low_nxt   = held_low_r;
    held_count_nxt = held_count_r;
    far_low_nxt    = far_low_r;
    if (in_ch.stream_first) begin
      phase_nxt = nfw_pkg::PH_HDR1;
      kind_nxt  = nfw_pkg::KIND_NONE;
    end else begin
      case (phase_r)
        nfw_pkg::PH_HDR0: phase_nxt = nfw_pkg::PH_HDR1;
        nfw_pkg::PH_HDR1: phase_nxt = nfw_pkg::PH_LOW;
        nfw_pkg::PH_LOW: begin
          if (wp_r < lim) begin
            held_low_nxt = b;
            phase_nxt    = nfw_pkg::PH_HIGH;
          end
        end
        nfw_pkg::PH_HIGH: begin
          if (b == nfw_pkg::NEAR_TAG || b == nfw_pkg::FAR_TAG) begin
            held_count_nxt = held_low_r;
            kind_nxt  = (b == nfw_pkg::NEAR_TAG) ? nfw_pkg::KIND_NEAR : nfw_pkg::KIND_FAR;
            phase_nxt = nfw_pkg::PH_ARG;
          end else begin
            phase_nxt = nfw_pkg::PH_LOW;
            lit_go    = 1'b1;
            lit_word  = {b, held_low_r};
          end
        end
        nfw_pkg::PH_ARG: begin
          if (held_count_r == 8'd0) begin
            phase_nxt = nfw_pkg::PH_LOW;
            kind_nxt  = nfw_pkg::KIND_NONE;
            lit_go    = 1'b1;
            lit_word  = {kind_byte, b};
          end else if (kind_r == nfw_pkg::KIND_NEAR) begin
            phase_nxt = nfw_pkg::PH_LOW;
            kind_nxt  = nfw_pkg::KIND_NONE;
            run_go    = 1'b1;
            run_src   = $signed(nfw_pkg::SRC_W'(wp_r)) - $signed(nfw_pkg::SRC_W'(b));
          end else begin
            far_low_nxt = b;
            phase_nxt   = nfw_pkg::PH_FARHI;
          end
        end
        nfw_pkg::PH_FARHI: begin
          phase_nxt = nfw_pkg::PH_LOW;
          kind_nxt  = nfw_pkg::KIND_NONE;
          run_go    = 1'b1;
          run_src   = $signed(nfw_pkg::SRC_W'({b, far_low_r}));
        end
        default: phase_nxt = nfw_pkg::PH_LOW;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    src_nxt   = src_r;
    rem_nxt   = rem_r;
    cut_nxt   = cut_r;
    ok_nxt    = ok_r;
    more_nxt  = more_r;
    slot_nxt  = slot_r;
    stage_w_nxt    = stage_w_r;
    stage_err_nxt  = stage_err_r;
    stage_cnt_nxt  = stage_cnt_r;
    stage_last_nxt = stage_last_r;
    stage_done_nxt = stage_done_r;
    stage_code_nxt = stage_code_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_w_nxt     = out_w_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    out_code_nxt  = out_code_r;
    mem_we    = 1'b0;
    mem_wdata = 16'h0000;
    mem_re    = 1'b0;
    case (state_r)
      nfw_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.stream_first) begin
            wp_nxt = '0;
          end else if (lit_go && wp_r < lim) begin
            mem_we    = 1'b1;
            mem_wdata = lit_word;
            wp_nxt    = wp_inc;
            stage_w_nxt[0] = lit_word;
            stage_cnt_nxt  = 3'd1;
            stage_last_nxt = 1'b1;
            stage_done_nxt = (wp_inc >= lim);
            stage_code_nxt = nfw_pkg::ERR_NONE;
            more_nxt  = 1'b0;
            state_nxt = nfw_pkg::ST_PUSH;
          end else if (run_go && wp_r < lim) begin
            src_nxt   = run_src;
            cut_nxt   = run_cut;
            rem_nxt   = run_cut ? 8'(lim - wp_r) : held_count_r;
            slot_nxt  = 2'd0;
            state_nxt = nfw_pkg::ST_READ;
          end
        end
      end
      nfw_pkg::ST_READ: begin
        mem_re    = 1'b1;
        ok_nxt    = src_ok;
        state_nxt = nfw_pkg::ST_WRITE;
      end
      nfw_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = cp_word;
        wp_nxt    = wp_inc;
        src_nxt   = src_r + nfw_pkg::SRC_W'(1);
        rem_nxt   = rem_r - 8'd1;
        slot_nxt  = slot_r + 2'd1;
        stage_w_nxt[slot_r] = cp_word;
        stage_err_nxt = stage_err_r || !ok_r;
        if (slot_r == 2'd3 || cp_last) begin
          stage_cnt_nxt  = 3'(slot_r) + 3'd1;
          stage_last_nxt = cp_last;
          stage_done_nxt = (wp_inc >= lim);
          stage_code_nxt = (stage_err_r || !ok_r) ? nfw_pkg::ERR_UNWRITTEN :
                           (cp_last && cut_r) ? nfw_pkg::ERR_CUT : nfw_pkg::ERR_NONE;
          more_nxt  = !cp_last;
          slot_nxt  = 2'd0;
          state_nxt = nfw_pkg::ST_PUSH;
        end else begin
          state_nxt = nfw_pkg::ST_READ;
        end
      end
      nfw_pkg::ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_w_nxt     = stage_w_r;
          out_cnt_nxt   = stage_cnt_r;
          out_last_nxt  = stage_last_r;
          out_done_nxt  = stage_done_r;
          out_code_nxt  = stage_code_r;
          for (int i = 0; i < 4; i++) begin
            stage_w_nxt[i] = 16'h0000;
          end
          stage_err_nxt = 1'b0;
          state_nxt = more_r ? nfw_pkg::ST_READ : nfw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nfw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      history_mem[wp_r[nfw_pkg::ADDR_W-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= history_mem[src_r[nfw_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nfw_pkg::ST_IDLE;
      phase_r      <= nfw_pkg::PH_HDR0;
      kind_r       <= nfw_pkg::KIND_NONE;
      cfg_r        <= 16'h0000;
      wp_r         <= '0;
      held_low_r   <= 8'h00;
      held_count_r <= 8'h00;
      far_low_r    <= 8'h00;
      out_valid_r  <= 1'b0;
      stage_err_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        stage_w_r[i] <= 16'h0000;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (in_fire) begin
        phase_r      <= phase_nxt;
        kind_r       <= kind_nxt;
        held_low_r   <= held_low_nxt;
        held_count_r <= held_count_nxt;
        far_low_r    <= far_low_nxt;
      end
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
      stage_err_r <= stage_err_nxt;
      stage_w_r   <= stage_w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    rem_r  <= rem_nxt;
    cut_r  <= cut_nxt;
    ok_r   <= ok_nxt;
    more_r <= more_nxt;
    slot_r <= slot_nxt;
    stage_cnt_r  <= stage_cnt_nxt;
    stage_last_r <= stage_last_nxt;
    stage_done_r <= stage_done_nxt;
    stage_code_r <= stage_code_nxt;
    out_w_r      <= out_w_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
    out_done_r   <= out_done_nxt;
    out_code_r   <= out_code_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.word_a      = out_w_r[0];
  assign out_ch.word_b      = out_w_r[1];
  assign out_ch.word_c      = out_w_r[2];
  assign out_ch.word_d      = out_w_r[3];
  assign out_ch.words_valid = out_cnt_r;
  assign out_ch.run_last    = out_last_r;
  assign out_ch.stream_done = out_done_r;
  assign out_ch.error_code  = out_code_r;

endmodule

// ===== sv/nfw_checker.sv =====
// port-level checks for the near/far word lz expander and their bind
module nfw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] word_a,
  input logic [15:0] word_b,
  input logic [15:0] word_c,
  input logic [15:0] word_d,
  input logic [2:0]  words_valid,
  input logic        run_last,
  input logic [1:0]  error_code
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(word_a) && $stable(words_valid)
                                && $stable(error_code))
    else $error("output beat changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> words_valid >= 3'd1 && words_valid <= 3'd4)
    else $error("word count out of range");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && words_valid == 3'd1 |-> word_b == 16'h0000 && word_c == 16'h0000
                                         && word_d == 16'h0000)
    else $error("unused words not zero");

  a_cut: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_code == nfw_pkg::ERR_CUT |-> run_last)
    else $error("cut reported before end of run");

endmodule

bind near_far_word_lz_expander nfw_checker u_nfw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .word_a      (out_ch.word_a),
  .word_b      (out_ch.word_b),
  .word_c      (out_ch.word_c),
  .word_d      (out_ch.word_d),
  .words_valid (out_ch.words_valid),
  .run_last    (out_ch.run_last),
  .error_code  (out_ch.error_code)
);
